// ===== hw/rtl/hfc_pkg.sv =====
// Package for the hex-real / IEEE double converter.
// Shared types, status codes and constants. No dependencies.
package hfc_pkg;

  localparam int WordW = 64;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNF   = 2'd2;
  localparam logic [1:0] ST_INFNAN = 2'd3;

  localparam logic OP_TO_HEX  = 1'b0;
  localparam logic OP_TO_IEEE = 1'b1;

  localparam logic [63:0] MagMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [63:0] value;
  } hfc_in_t;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  status;
  } hfc_out_t;

  // position of highest set bit of a 64-bit word (0 when zero)
  function automatic logic [5:0] top_bit(input logic [63:0] x);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/hfc_if.sv =====
// Valid/ready channel carrying one word.
// Depends on nothing; payload type is a parameter.
interface hfc_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hfc_decode.sv =====
// Stage 1: field split, leading-one position, special-case classification.
// Depends on hfc_pkg.
module hfc_decode (
  input  logic                 clk,
  input  logic                 en,
  input  hfc_pkg::hfc_in_t     in_word,
  output logic                 op_r,
  output logic                 sign_r,
  output logic [63:0]          mant_r,
  output logic [5:0]           pos_r,
  output logic signed [12:0]   exp_r,
  output logic                 zero_r,
  output logic                 infnan_r
);
  import hfc_pkg::*;
  logic [63:0] m_nxt;
  logic signed [12:0] e_nxt;
  logic [10:0] bexp;

  assign bexp = in_word.value[62:52];

  always_comb begin
    if (in_word.opcode == OP_TO_IEEE) begin
      m_nxt = {8'd0, in_word.value[55:0]};
      // binary exponent offset: 4*hexp - 312
      e_nxt = $signed({4'd0, in_word.value[62:56], 2'b00}) - 13'sd312;
    end else if (bexp == 11'd0) begin
      m_nxt = {12'd0, in_word.value[51:0]};
      e_nxt = -13'sd1074;
    end else begin
      m_nxt = {11'd0, 1'b1, in_word.value[51:0]};
      e_nxt = $signed({2'd0, bexp}) - 13'sd1075;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r     <= in_word.opcode;
      sign_r   <= in_word.value[63];
      mant_r   <= m_nxt;
      pos_r    <= top_bit(m_nxt);
      exp_r    <= e_nxt;
      zero_r   <= (m_nxt == 64'd0);
      infnan_r <= (in_word.opcode == OP_TO_HEX) && (bexp == 11'h7FF);
    end
  end
endmodule

// ===== hw/rtl/hfc_shift.sv =====
// Stage 2: align mantissa, compute rounding bits and target exponent.
// Depends on hfc_pkg.
module hfc_shift (
  input  logic               clk,
  input  logic               en,
  input  logic               op,
  input  logic               sign,
  input  logic [63:0]        mant,
  input  logic [5:0]         pos,
  input  logic signed [12:0] expo,
  input  logic               zero,
  input  logic               infnan,
  output logic               op_r,
  output logic               sign_r,
  output logic [55:0]        q_r,
  output logic               rup_r,
  output logic signed [12:0] e_r,
  output logic               zero_r,
  output logic               infnan_r
);
  import hfc_pkg::*;
  logic [5:0]  sh;
  logic [63:0] rmask, rem, half, qd;
  logic        rup;
  logic [55:0] q_nxt;
  logic signed [12:0] b, k, s, e_nxt;

  always_comb begin
    sh = 6'd0; rmask = '0; rem = '0; half = '0; qd = '0; rup = 1'b0;
    k = '0; s = '0;
    b = $signed({7'd0, pos}) + expo;
    if (op == OP_TO_IEEE) begin
      e_nxt = b;
      if (pos > 6'd52) begin
        sh    = pos - 6'd52;
        rmask = (64'd1 << sh) - 64'd1;
        rem   = mant & rmask;
        half  = 64'd1 << (sh - 6'd1);
        qd    = mant >> sh;
        rup   = (rem > half) || ((rem == half) && qd[0]);
      end else begin
        qd = mant << (6'd52 - pos);
      end
      q_nxt = qd[55:0];
    end else begin
      // k = floor((b+1076)/4) - 268; b+1076 is nonnegative
      k = $signed({2'b00, 11'((b + 13'sd1076) >>> 2)}) - 13'sd268;
      e_nxt = k + 13'sd64;
      s = expo + 13'sd56 - (k <<< 2);
      q_nxt = 56'(mant << s[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= op; sign_r <= sign; q_r <= q_nxt; rup_r <= rup;
      e_r <= e_nxt; zero_r <= zero; infnan_r <= infnan;
    end
  end
endmodule

// ===== hw/rtl/hfc_pack.sv =====
// Stage 3: rounding increment, range checks and output packing.
// Depends on hfc_pkg.
module hfc_pack (
  input  logic               clk,
  input  logic               en,
  input  logic               op,
  input  logic               sign,
  input  logic [55:0]        q,
  input  logic               rup,
  input  logic signed [12:0] e,
  input  logic               zero,
  input  logic               infnan,
  output hfc_pkg::hfc_out_t  out_r
);
  import hfc_pkg::*;
  hfc_out_t    o_nxt;
  logic [53:0] qr;
  logic signed [12:0] ee, be;

  always_comb begin
    qr = {1'b0, q[52:0]} + {53'd0, rup};
    ee = e;
    be = '0;
    if (op == OP_TO_IEEE) begin
      if (qr[53]) ee = e + 13'sd1;  // carry into next binade
      be = ee + 13'sd1023;
      if (zero) o_nxt = '{result: {sign, 63'd0}, status: ST_OK};
      else o_nxt = '{result: {sign, be[10:0], qr[51:0]}, status: ST_OK};
    end else if (infnan) begin
      o_nxt = '{result: {sign, MagMax[62:0]}, status: ST_INFNAN};
    end else if (zero) begin
      o_nxt = '{result: 64'd0, status: ST_OK};
    end else if (e > 13'sd127) begin
      o_nxt = '{result: {sign, MagMax[62:0]}, status: ST_OVF};
    end else if (e < 13'sd0) begin
      o_nxt = '{result: 64'd0, status: ST_UNF};
    end else begin
      o_nxt = '{result: {sign, e[6:0], q}, status: ST_OK};
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= o_nxt;
  end
endmodule

// ===== hw/rtl/hex_float_ieee_double_converter_core.sv =====
// Hex-real <-> IEEE double converter, top level.
// Pipeline stages: decode, align/round, pack. Throughput: one word per cycle while the output is taken.
// Pipeline stalls as a whole when the output word is not taken; nothing lost.
// Reset (rst_n, synchronous) clears the stage valid bits only.
// Depends on hfc_pkg, hfc_if, hfc_decode, hfc_shift, hfc_pack.
module hex_float_ieee_double_converter_core (
  input logic clk,
  input logic rst_n,
  hfc_if.sink   in_ch,
  hfc_if.source out_ch
);
  import hfc_pkg::*;
  logic v1_r, v2_r, v3_r, adv;
  logic op1, s1, z1, i1, op2, s2, z2, i2, rup2;
  logic [63:0] m1;
  logic [5:0] p1;
  logic signed [12:0] e1, e2;
  logic [55:0] q2;
  hfc_out_t o3;

  assign adv = !v3_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  hfc_decode u_dec (.clk, .en(adv), .in_word(in_ch.data), .op_r(op1), .sign_r(s1),
    .mant_r(m1), .pos_r(p1), .exp_r(e1), .zero_r(z1), .infnan_r(i1));
  hfc_shift u_sh (.clk, .en(adv), .op(op1), .sign(s1), .mant(m1), .pos(p1), .expo(e1),
    .zero(z1), .infnan(i1), .op_r(op2), .sign_r(s2), .q_r(q2), .rup_r(rup2),
    .e_r(e2), .zero_r(z2), .infnan_r(i2));
  hfc_pack u_pk (.clk, .en(adv), .op(op2), .sign(s2), .q(q2), .rup(rup2), .e(e2),
    .zero(z2), .infnan(i2), .out_r(o3));

  assign out_ch.valid = v3_r;
  assign out_ch.data  = o3;
endmodule
